>>> rtl/four_level_page_table_walker_core_defines.svh
// Assertion macros for the page table walker.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_DEFINES_SVH

// check on every clock edge outside reset
`define PTW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check on every clock edge, reset included
`define PTW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ptw_pkg.sv
`timescale 1ns / 1ps
package ptw_pkg;

  localparam logic [1:0] OP_TRANSLATE = 2'd0;
  localparam logic [1:0] OP_MAP       = 2'd1;
  localparam logic [1:0] OP_UNMAP     = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FAULT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] LVL_LEAF = 2'd3;

  localparam int unsigned IDX_W   = 9;
  localparam int unsigned FRAME_W = 40;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_EVAL  = 5'b01000,
    S_DONE  = 5'b10000
  } ptw_state_e;

  typedef struct packed {
    logic clr_step;
    logic load_req;
    logic mem_rd;
    logic eval;
    logic load_out;
  } ptw_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic finish;
    logic out_free;
  } ptw_sts_t;

  function automatic logic [IDX_W-1:0] level_idx(input logic [47:0] va,
                                                 input logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

>>> rtl/ptw_ctrl.sv
`timescale 1ns / 1ps
module ptw_ctrl import ptw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  ptw_sts_t sts_i,
  output ptw_cmd_t cmd_o,
  output logic     idle_o
);

  ptw_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_READ;
        end
      end
      S_READ: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.finish ? S_DONE : S_READ;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  assign idle_o = (state_q == S_IDLE);

endmodule

>>> rtl/ptw_dp.sv
`timescale 1ns / 1ps
`include "four_level_page_table_walker_core_defines.svh"
module ptw_dp import ptw_pkg::*; #(
  parameter int unsigned POOL_PAGES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ptw_cmd_t    cmd_i,
  output ptw_sts_t    sts_o,
  input  logic        cfg_we_i,
  input  logic [51:0] cfg_wdata_i,
  input  logic [1:0]  op_i,
  input  logic [47:0] virt_addr_i,
  input  logic [51:0] phys_addr_in_i,
  input  logic [63:0] leaf_flags_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [51:0] phys_addr_out_o,
  output logic        tlb_invalidate_o
);

  localparam int unsigned PAGE_W = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int unsigned NFP_W  = $clog2(POOL_PAGES + 1);
  localparam int unsigned ADDR_W = PAGE_W + IDX_W;
  localparam int unsigned DEPTH  = POOL_PAGES * (2 ** IDX_W);

  // entry store: bit 64 marks a write made after the page was allocated
  logic [64:0] mem_q [DEPTH];
  logic [64:0] rdata_q;
  logic        mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [64:0]       mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  logic [51:0]       pool_base_q;
  logic [NFP_W-1:0]  nfp_q, nfp_d;
  logic [ADDR_W-1:0] clr_q;

  logic [1:0]        op_q;
  logic [47:0]       va_q;
  logic [51:0]       pa_q;
  logic [63:0]       flags_q;
  logic [PAGE_W-1:0] page_q, page_d;
  logic [1:0]        level_q, level_d;

  logic [1:0]  res_status_q, res_status_d;
  logic [51:0] res_addr_q, res_addr_d;
  logic        res_inval_q, res_inval_d;

  logic        out_valid_q;
  logic [1:0]  out_status_q;
  logic [51:0] out_addr_q;
  logic        out_inval_q;

  logic [63:0]        entry;
  logic               present;
  logic [FRAME_W-1:0] frame;
  logic [FRAME_W-1:0] base_frame;
  logic [FRAME_W-1:0] diff;
  logic               in_pool;
  logic               pool_full;
  logic [FRAME_W-1:0] fresh_frame;
  logic               finish;
  logic               eval_we;
  logic [63:0]        eval_wdata;

  assign base_frame = pool_base_q[51:12];
  assign entry      = ((NFP_W'(page_q) < nfp_q) && !rdata_q[64]) ? 64'd0 : rdata_q[63:0];
  assign present    = entry[0];
  assign frame      = entry[51:12];
  assign diff       = frame - base_frame;
  assign in_pool    = (frame >= base_frame) && (diff < FRAME_W'(POOL_PAGES));
  assign pool_full  = (nfp_q >= NFP_W'(POOL_PAGES));
  assign fresh_frame = base_frame + FRAME_W'(nfp_q);
  assign mem_raddr  = {page_q, level_idx(va_q, level_q)};

  always_comb begin
    finish       = 1'b0;
    eval_we      = 1'b0;
    eval_wdata   = '0;
    page_d       = page_q;
    level_d      = level_q;
    nfp_d        = nfp_q;
    res_status_d = ST_FAULT;
    res_addr_d   = '0;
    res_inval_d  = 1'b0;
    if (op_q inside {OP_TRANSLATE, OP_UNMAP}) begin
      if (level_q != LVL_LEAF) begin
        if (present && in_pool) begin
          page_d  = diff[PAGE_W-1:0];
          level_d = level_q + 2'd1;
        end else begin
          finish = 1'b1;
        end
      end else begin
        finish = 1'b1;
        if (present) begin
          res_status_d = ST_OK;
          if (op_q == OP_TRANSLATE) begin
            res_addr_d = {frame, va_q[11:0]};
          end else begin
            eval_we     = 1'b1;
            res_inval_d = 1'b1;
          end
        end
      end
    end else if (op_q == OP_MAP) begin
      if (level_q != LVL_LEAF) begin
        if (present) begin
          if (in_pool) begin
            page_d  = diff[PAGE_W-1:0];
            level_d = level_q + 2'd1;
          end else begin
            finish = 1'b1;
          end
        end else if (pool_full) begin
          finish       = 1'b1;
          res_status_d = ST_FULL;
        end else begin
          eval_we    = 1'b1;
          eval_wdata = {12'd0, fresh_frame, 12'h003};
          page_d     = nfp_q[PAGE_W-1:0];
          level_d    = level_q + 2'd1;
          nfp_d      = nfp_q + NFP_W'(1);
        end
      end else begin
        finish       = 1'b1;
        eval_we      = 1'b1;
        eval_wdata   = {12'd0, pa_q[51:12], 12'd0} | flags_q | 64'd1;
        res_status_d = ST_OK;
      end
    end else begin
      finish = 1'b1;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = '0;
    if (cmd_i.clr_step) begin
      mem_we = 1'b1;
    end else if (cmd_i.eval && eval_we) begin
      mem_we    = 1'b1;
      mem_waddr = mem_raddr;
      mem_wdata = {(NFP_W'(page_q) < nfp_d), eval_wdata};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= '0;
      nfp_q       <= NFP_W'(1);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pool_base_q <= cfg_wdata_i;
      end
      if (cmd_i.eval) begin
        nfp_q <= nfp_d;
      end
      if (cmd_i.clr_step && !sts_o.clr_last) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      op_q    <= op_i;
      va_q    <= virt_addr_i;
      pa_q    <= phys_addr_in_i;
      flags_q <= leaf_flags_i;
      page_q  <= '0;
      level_q <= '0;
    end else if (cmd_i.eval) begin
      page_q  <= page_d;
      level_q <= level_d;
    end
    if (cmd_i.eval && finish) begin
      res_status_q <= res_status_d;
      res_addr_q   <= res_addr_d;
      res_inval_q  <= res_inval_d;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
      out_inval_q  <= res_inval_q;
    end
  end

  assign sts_o.clr_last = (clr_q == ADDR_W'(DEPTH - 1));
  assign sts_o.finish   = finish;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign phys_addr_out_o  = out_addr_q;
  assign tlb_invalidate_o = out_inval_q;

  `PTW_ASSERT(a_nfp_range, clk_i, rst_ni, nfp_q <= NFP_W'(POOL_PAGES), "free page count past pool")
  `PTW_ASSERT_ALWAYS(a_nfp_nonzero, clk_i, !rst_ni || (nfp_q != '0), "root page handed out")
  `PTW_ASSERT(a_we_phase, clk_i, rst_ni, mem_we |-> (cmd_i.clr_step || cmd_i.eval), "stray store write")
  `PTW_ASSERT(a_inval_ok, clk_i, rst_ni, (out_valid_q && out_inval_q) |-> (out_status_q == ST_OK), "invalidate on failed transfer")
  `PTW_ASSERT(a_addr_ok, clk_i, rst_ni, (out_valid_q && (out_addr_q != '0)) |-> (out_status_q == ST_OK), "address on failed transfer")

endmodule

>>> rtl/four_level_page_table_walker_core.sv
// A request is loaded; each level walked then takes one entry store read and one evaluation,
// then the result moves to the output register. A new request is taken only while idle.
// The result sits in an output register, so a new request is taken while it waits.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes all POOL_PAGES * 512
// table store entries and holds in_stall_o high; configuration writes are still taken.
`timescale 1ns / 1ps
module four_level_page_table_walker_core import ptw_pkg::*; #(
  parameter int unsigned POOL_PAGES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [51:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [47:0] virt_addr_i,
  input  logic [51:0] phys_addr_in_i,
  input  logic [63:0] leaf_flags_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [51:0] phys_addr_out_o,
  output logic        tlb_invalidate_o
);

  ptw_cmd_t cmd;
  ptw_sts_t sts;
  logic     idle;

  ptw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .idle_o     (idle)
  );

  ptw_dp #(
    .POOL_PAGES (POOL_PAGES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .op_i             (op_i),
    .virt_addr_i      (virt_addr_i),
    .phys_addr_in_i   (phys_addr_in_i),
    .leaf_flags_i     (leaf_flags_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .phys_addr_out_o  (phys_addr_out_o),
    .tlb_invalidate_o (tlb_invalidate_o)
  );

  assign in_stall_o = !idle;

endmodule
